// ===== src/fmsc_pkg.sv =====
// Shared types, constants and helpers of the switch-select block.
`default_nettype none
package fmsc_pkg;

    localparam int VAL_W  = 32;
    localparam int COEF_W = 32;
    localparam int REF_W  = 31;
    localparam int MOP_W  = 34;
    localparam int MP_W   = 2 * MOP_W;
    localparam int NUM_W  = 64;
    localparam int TERM_W = 40;
    localparam int ACC_W  = 42;

    // Switch table, indexed by candidate: (1,0) (1,1) (0,0) (0,1)
    localparam logic [3:0] SW_ONE = 4'b0011;
    localparam logic [3:0] SW_TWO = 4'b1010;

    typedef enum logic [2:0] {
        REG_TS_OVER_LB = 3'd0,
        REG_TS_OVER_LS = 3'd1,
        REG_TS_OVER_CO = 3'd2,
        REG_VO_DECAY   = 3'd3,
        REG_REF_VO     = 3'd4,
        REG_REF_IB_MAG = 3'd5,
        REG_REF_POWER  = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_ONE   = 3'd1,
        MODE_TWO   = 3'd2,
        MODE_THREE = 3'd3,
        MODE_FOUR  = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REFMUL,
        S_REFTAKE,
        S_DIVGO,
        S_DIVWAIT,
        S_PMUL,
        S_PTAKE,
        S_STEP1,
        S_CAND,
        S_SQA,
        S_SQB,
        S_SQW,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [VAL_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] quot;
    } t_div_rsp;

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (x > hi) begin
            return VAL_W'(hi);
        end else if (x < lo) begin
            return VAL_W'(lo);
        end
        return x[VAL_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== src/fmsc_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module fmsc_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [fmsc_pkg::MOP_W-1:0]    i_a,
    input  wire logic signed [fmsc_pkg::MOP_W-1:0]    i_b,
    output logic signed [fmsc_pkg::MP_W-1:0]          o_p
);
    import fmsc_pkg::*;

    logic signed [MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== src/fmsc_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating and saturating.
`default_nettype none
module fmsc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fmsc_pkg::t_div_req i_req,
    output fmsc_pkg::t_div_rsp      o_rsp
);
    import fmsc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              r_run;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [NUM_W-1:0]  r_sh;
    logic [VAL_W-1:0]  r_rem;
    logic [VAL_W-1:0]  r_dm;

    logic [VAL_W:0]    rem_s;
    logic              qbit;
    logic [VAL_W:0]    rem_n;

    always_comb begin
        rem_s = {r_rem, r_sh[NUM_W-1]};
        qbit  = (rem_s >= {1'b0, r_dm});
        rem_n = qbit ? (rem_s - {1'b0, r_dm}) : rem_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg <= i_req.num[NUM_W-1] ^ i_req.den[VAL_W-1];
                r_sh  <= i_req.num[NUM_W-1] ? NUM_W'(-i_req.num) : NUM_W'(i_req.num);
                r_dm  <= i_req.den[VAL_W-1] ? VAL_W'(-i_req.den) : VAL_W'(i_req.den);
                r_rem <= '0;
                r_cnt <= '0;
                if (i_req.den == '0) begin
                    // zero divisor gives zero
                    r_sh   <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                r_rem <= rem_n[VAL_W-1:0];
                r_sh  <= {r_sh[NUM_W-2:0], qbit};
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (r_neg) begin
            if (r_sh > NUM_W'(64'h8000_0000)) begin
                o_rsp.quot = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                o_rsp.quot = VAL_W'(-r_sh);
            end
        end else begin
            if (r_sh > NUM_W'(64'h7FFF_FFFF)) begin
                o_rsp.quot = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                o_rsp.quot = r_sh[VAL_W-1:0];
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/fcs_mpc_converter_switch_select.sv =====
// Top level: predictive switch selector with shared multiplier and divider.
//
// Channel  Dir  Handshake                  Payload
// s_axis   in   i_s_tvalid / o_s_tready    tdata 160b measurements, tuser 3b mode
// m_axis   out  o_m_tvalid / i_m_tready    tdata 104b switches, bias, references
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_addr register index, i_cfg_data value
//
// An item with a hold code needs the product steps and a pair of squares per
// candidate from acceptance back to ready; the shared multiplier forms eleven
// to sixteen products per item. Modes two and four also wait on the bit-serial
// divider, and modes one and three form a product before it; a zero divisor
// skips the bit-serial steps.
// Reset is synchronous, active low, and restores the register defaults and
// clears all held settings. A result waits in the output register while the
// next item is taken; the sequencer holds at its end until that result leaves.
`default_nettype none
module fcs_mpc_converter_switch_select (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input_voltage[31:0], source_current[63:32], output_voltage[95:64],
    // battery_voltage[127:96], battery_current[159:128]
    input  wire logic [159:0] i_s_tdata,
    // mode[2:0]
    input  wire logic [2:0]   i_s_tuser,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // switch_one[0], switch_two[1], bias_bit[2], vo_reference[33:3],
    // battery_current_reference[65:34], source_current_reference[97:66], zero[103:98]
    output logic [103:0]      o_m_tdata,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_addr,
    input  wire logic [31:0]  i_cfg_data
);
    import fmsc_pkg::*;

    // configuration
    logic [COEF_W-1:0] r_c_lb, r_c_ls, r_c_co, r_c_dec;
    logic [REF_W-1:0]  r_ref_vo, r_ref_mag, r_ref_p;

    // held state; the battery reference reaches +2^31 when a negated quotient saturates
    logic              r_prev1, r_prev2, r_bias;
    logic [1:0]        r_best, r_first, r_last;
    logic signed [VAL_W:0]   r_bref;
    logic signed [VAL_W-1:0] r_sref;

    // item and work registers
    logic signed [VAL_W-1:0] r_vin, r_ils, r_vo, r_vb, r_ilb;
    logic [2:0]              r_mode;
    logic [3:0]              r_step;
    logic signed [TERM_W-1:0] r_t [9];
    logic signed [VAL_W-1:0] r_ilb1, r_ils1, r_vo1;
    logic [2:0]              r_k;
    logic                    r_have;
    logic signed [VAL_W:0]   r_da;
    logic signed [VAL_W+1:0] r_db;
    logic [64:0]             r_sa, r_sb;
    logic [65:0]             r_bscore;

    logic                    r_ovalid;
    logic [103:0]            r_odata;

    t_state r_state, n_state;

    logic signed [MOP_W-1:0] mul_a, mul_b;
    logic signed [MP_W-1:0]  mul_p;
    t_div_req                div_req;
    t_div_rsp                div_rsp;

    logic signed [NUM_W-1:0] p32;
    logic signed [TERM_W-1:0] mterm;
    logic                    s_acc;
    logic                    db, ds, dbk, dsk, m0, m1;
    logic signed [ACC_W-1:0] acc_ilb, acc_ils, acc_vo, acc_ilb2, acc_ils2;
    logic signed [VAL_W-1:0] ilb2, ils2;
    logic [65:0]             score;
    logic                    out_free;

    fmsc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    fmsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign out_free    = !r_ovalid || i_m_tready;

    assign p32   = NUM_W'({r_ref_p, 16'h0000});
    assign mterm = mul_p[63:24];

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_REFMUL: begin
                mul_a = MOP_W'(r_ref_mag);
                mul_b = MOP_W'(r_vb);
            end
            S_PMUL: begin
                case (r_step)
                    4'd0: begin mul_a = MOP_W'(r_c_lb);  mul_b = MOP_W'(r_vo);  end
                    4'd1: begin mul_a = MOP_W'(r_c_lb);  mul_b = MOP_W'(r_vb);  end
                    4'd2: begin mul_a = MOP_W'(r_c_ls);  mul_b = MOP_W'(r_vo);  end
                    4'd3: begin mul_a = MOP_W'(r_c_ls);  mul_b = MOP_W'(r_vin); end
                    4'd4: begin mul_a = MOP_W'(r_c_co);  mul_b = MOP_W'(r_ilb); end
                    4'd5: begin mul_a = MOP_W'(r_c_co);  mul_b = MOP_W'(r_ils); end
                    4'd6: begin mul_a = MOP_W'(r_c_dec); mul_b = MOP_W'(r_vo);  end
                    4'd7: begin mul_a = MOP_W'(r_c_lb);  mul_b = MOP_W'(r_vo1); end
                    default: begin mul_a = MOP_W'(r_c_ls); mul_b = MOP_W'(r_vo1); end
                endcase
            end
            S_SQA: begin
                mul_a = MOP_W'(r_da);
                mul_b = MOP_W'(r_da);
            end
            S_SQB: begin
                mul_a = MOP_W'(r_db);
                mul_b = MOP_W'(r_db);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider request
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = p32;
        div_req.den   = r_vin;
        if (r_state == S_REFTAKE) begin
            div_req.start = 1'b1;
            div_req.num   = (r_mode == MODE_THREE) ? (p32 - mul_p[NUM_W-1:0])
                                                   : (p32 + mul_p[NUM_W-1:0]);
        end else if (r_state == S_DIVGO) begin
            div_req.start = 1'b1;
            div_req.den   = (r_mode == MODE_FOUR) ? r_vb : r_vin;
        end
    end

    // first-step and second-step predictions
    always_comb begin
        db = !r_prev2 && (r_prev1 || r_bias);
        ds = !(r_prev1 && r_prev2);
        acc_ilb = ACC_W'(r_ilb) + (db ? ACC_W'(r_t[0]) : '0) - ACC_W'(r_t[1]);
        acc_ils = ACC_W'(r_ils) - (ds ? ACC_W'(r_t[2]) : '0) + ACC_W'(r_t[3]);
        acc_vo  = (ds ? ACC_W'(r_t[5]) : '0) - (db ? ACC_W'(r_t[4]) : '0)
                  + ACC_W'(r_t[6]);
        m0  = SW_ONE[r_k[1:0]];
        m1  = SW_TWO[r_k[1:0]];
        dbk = !m1 && (m0 || r_bias);
        dsk = !(m0 && m1);
        acc_ilb2 = ACC_W'(r_ilb1) + (dbk ? ACC_W'(r_t[7]) : '0) - ACC_W'(r_t[1]);
        acc_ils2 = ACC_W'(r_ils1) - (dsk ? ACC_W'(r_t[8]) : '0) + ACC_W'(r_t[3]);
        ilb2  = sat32(acc_ilb2);
        ils2  = sat32(acc_ils2);
        score = 66'(r_sa) + 66'(r_sb);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (i_s_tuser)
                        MODE_ONE, MODE_THREE: n_state = S_REFMUL;
                        MODE_TWO, MODE_FOUR:  n_state = S_DIVGO;
                        default:              n_state = S_PMUL;
                    endcase
                end
            end
            S_REFMUL:  n_state = S_REFTAKE;
            S_REFTAKE: n_state = S_DIVWAIT;
            S_DIVGO:   n_state = S_DIVWAIT;
            S_DIVWAIT: n_state = div_rsp.done ? S_PMUL : S_DIVWAIT;
            S_PMUL:    n_state = S_PTAKE;
            S_PTAKE: begin
                if (r_step == 4'd6) begin
                    n_state = S_STEP1;
                end else if (r_step == 4'd8) begin
                    n_state = S_CAND;
                end else begin
                    n_state = S_PMUL;
                end
            end
            S_STEP1:   n_state = S_PMUL;
            S_CAND:    n_state = (r_k > {1'b0, r_last}) ? S_DONE : S_SQA;
            S_SQA:     n_state = S_SQB;
            S_SQB:     n_state = S_SQW;
            S_SQW:     n_state = S_CMP;
            S_CMP:     n_state = S_CAND;
            S_DONE:    n_state = out_free ? S_IDLE : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_lb    <= 32'd55924;
            r_c_ls    <= 32'd47934;
            r_c_co    <= 32'd419430;
            r_c_dec   <= 32'd16774595;
            r_ref_vo  <= 31'd26214400;
            r_ref_mag <= 31'd70779;
            r_ref_p   <= 31'd65536000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_TS_OVER_LB: r_c_lb    <= i_cfg_data;
                REG_TS_OVER_LS: r_c_ls    <= i_cfg_data;
                REG_TS_OVER_CO: r_c_co    <= i_cfg_data;
                REG_VO_DECAY:   r_c_dec   <= i_cfg_data;
                REG_REF_VO:     r_ref_vo  <= i_cfg_data[REF_W-1:0];
                REG_REF_IB_MAG: r_ref_mag <= i_cfg_data[REF_W-1:0];
                REG_REF_POWER:  r_ref_p   <= i_cfg_data[REF_W-1:0];
                default: ;
            endcase
        end
    end

    // held settings and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev1  <= 1'b0;
            r_prev2  <= 1'b0;
            r_bias   <= 1'b0;
            r_best   <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_bref   <= '0;
            r_sref   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (s_acc) begin
                // apply mode settings; the divider fills in the rest
                case (i_s_tuser)
                    MODE_ONE: begin
                        r_bias <= 1'b0; r_first <= 2'd0; r_last <= 2'd2;
                        r_bref <= (VAL_W+1)'(r_ref_mag);
                    end
                    MODE_TWO: begin
                        r_bias <= 1'b0; r_first <= 2'd1; r_last <= 2'd2;
                        r_bref <= '0;
                    end
                    MODE_THREE: begin
                        r_bias <= 1'b1; r_first <= 2'd1; r_last <= 2'd3;
                        r_bref <= -(VAL_W+1)'(r_ref_mag);
                    end
                    MODE_FOUR: begin
                        r_bias <= 1'b1; r_first <= 2'd2; r_last <= 2'd3;
                        r_sref <= '0;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_DIVWAIT && div_rsp.done) begin
                if (r_mode == MODE_FOUR) begin
                    r_bref <= -((VAL_W+1)'(div_rsp.quot));
                end else begin
                    r_sref <= div_rsp.quot;
                end
            end
            if (r_state == S_CMP && (!r_have || score < r_bscore)) begin
                r_best <= r_k[1:0];
            end
            if (r_state == S_DONE && out_free) begin
                r_prev1  <= SW_ONE[r_best];
                r_prev2  <= SW_TWO[r_best];
                r_ovalid <= 1'b1;
                r_odata  <= {6'b0, r_sref, r_bref[VAL_W-1:0], r_ref_vo, r_bias,
                             SW_TWO[r_best], SW_ONE[r_best]};
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_vin  <= i_s_tdata[31:0];
            r_ils  <= i_s_tdata[63:32];
            r_vo   <= i_s_tdata[95:64];
            r_vb   <= i_s_tdata[127:96];
            r_ilb  <= i_s_tdata[159:128];
            r_mode <= i_s_tuser;
            r_step <= '0;
        end
        if (r_state == S_PTAKE) begin
            r_t[r_step] <= mterm;
            r_step      <= r_step + 4'd1;
        end
        if (r_state == S_STEP1) begin
            r_ilb1 <= sat32(acc_ilb);
            r_ils1 <= sat32(acc_ils);
            r_vo1  <= sat32(acc_vo);
            r_k    <= {1'b0, r_first};
            r_have <= 1'b0;
        end
        if (r_state == S_CAND) begin
            r_da <= (VAL_W+1)'(ils2) - (VAL_W+1)'(r_sref);
            r_db <= (VAL_W+2)'(ilb2) - (VAL_W+2)'(r_bref);
        end
        if (r_state == S_SQB) begin
            r_sa <= mul_p[64:0];
        end
        if (r_state == S_SQW) begin
            // the square is kept modulo 2^64
            r_sb <= {1'b0, mul_p[63:0]};
        end
        if (r_state == S_CMP) begin
            // strict compare keeps the earlier candidate on a tie
            if (!r_have || score < r_bscore) begin
                r_bscore <= score;
            end
            r_have <= 1'b1;
            r_k    <= r_k + 3'd1;
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb_fcs_mpc_converter_switch_select.sv =====
// Testbench for the predictive switch selector: random and directed samples checked by a model.
`default_nettype none
module tb_fcs_mpc_converter_switch_select;
    timeunit 1ns;
    timeprecision 1ps;
    import fmsc_pkg::*;

    // Expected output word of one sample
    typedef struct {
        logic        sw_one;
        logic        sw_two;
        logic        bias;
        logic [30:0] vo_ref;
        logic [31:0] ib_ref;
        logic [31:0] is_ref;
    } t_choice;

    // Predicts each chosen switch pair and keeps the queue of pending choices
    class switch_scoreboard;
        logic [31:0] k_lb, k_ls, k_co, k_decay;
        logic [30:0] vo_ref_r, ib_mag, p_load;
        logic        prev_one, prev_two, bias;
        logic [1:0]  winner, first_k, last_k;
        longint      ib_ref, is_ref;
        t_choice     pending[$];
        int          errors;
        int          checked;

        function new();
            k_lb = 55924; k_ls = 47934; k_co = 419430; k_decay = 16774595;
            vo_ref_r = 26214400; ib_mag = 70779; p_load = 65536000;
            prev_one = 0; prev_two = 0; bias = 0; winner = 0;
            first_k = 0; last_k = 0; ib_ref = 0; is_ref = 0;
            errors = 0; checked = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_TS_OVER_LB: k_lb = v;
                REG_TS_OVER_LS: k_ls = v;
                REG_TS_OVER_CO: k_co = v;
                REG_VO_DECAY:   k_decay = v;
                REG_REF_VO:     vo_ref_r = v[30:0];
                REG_REF_IB_MAG: ib_mag = v[30:0];
                REG_REF_POWER:  p_load = v[30:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // coefficient times value, floor shift by 24 (arithmetic shift floors)
        function longint scale(logic [31:0] c, longint v);
            logic signed [95:0] p;
            p = $signed({64'd0, c}) * 96'(v);
            p = p >>> 24;
            return longint'(p);
        endfunction

        function longint quot(longint num, longint den);
            if (den == 0) return 0;
            return clip(num / den);
        endfunction

        // squared distance, kept modulo 2^64
        function logic [64:0] sq(longint a, longint b);
            longint d;
            logic [64:0] m;
            logic [64:0] p;
            d = a - b;
            m = (d < 0) ? 65'(-d) : 65'(d);
            p = m * m;
            return {1'b0, p[63:0]};
        endfunction

        function void note_sample(logic [159:0] d, logic [2:0] mode);
            longint vin, ils, vo, vb, ilb, mag, p32, ilb1, ils1, vo1, ilb2, ils2;
            logic s1, s2, db, ds, m0, m1, dbk, dsk, have;
            logic [64:0] score, best;
            t_choice c;
            vin = longint'($signed(d[31:0]));
            ils = longint'($signed(d[63:32]));
            vo  = longint'($signed(d[95:64]));
            vb  = longint'($signed(d[127:96]));
            ilb = longint'($signed(d[159:128]));
            mag = longint'(ib_mag);
            p32 = longint'(p_load) * 65536;
            case (mode)
                MODE_ONE: begin
                    bias = 0; first_k = 0; last_k = 2;
                    ib_ref = mag; is_ref = quot(vb * mag + p32, vin);
                end
                MODE_TWO: begin
                    bias = 0; first_k = 1; last_k = 2;
                    ib_ref = 0; is_ref = quot(p32, vin);
                end
                MODE_THREE: begin
                    bias = 1; first_k = 1; last_k = 3;
                    ib_ref = -mag; is_ref = quot(-(vb * mag) + p32, vin);
                end
                MODE_FOUR: begin
                    bias = 1; first_k = 2; last_k = 3;
                    ib_ref = -quot(p32, vb); is_ref = 0;
                end
                default: ;
            endcase
            s1 = prev_one; s2 = prev_two;
            db = !s2 && (s1 || bias);
            ds = !(s1 && s2);
            ilb1 = clip(ilb + (db ? scale(k_lb, vo) : 0) - scale(k_lb, vb));
            ils1 = clip(ils - (ds ? scale(k_ls, vo) : 0) + scale(k_ls, vin));
            vo1 = clip(-(db ? scale(k_co, ilb) : 0) + (ds ? scale(k_co, ils) : 0)
                       + scale(k_decay, vo));
            have = 0;
            best = '0;
            for (int k = first_k; k <= last_k; k++) begin
                m0 = SW_ONE[k]; m1 = SW_TWO[k];
                dbk = !m1 && (m0 || bias);
                dsk = !(m0 && m1);
                ilb2 = clip(ilb1 + (dbk ? scale(k_lb, vo1) : 0) - scale(k_lb, vb));
                ils2 = clip(ils1 - (dsk ? scale(k_ls, vo1) : 0) + scale(k_ls, vin));
                score = sq(ils2, is_ref) + sq(ilb2, ib_ref);
                // earlier candidate keeps a tie
                if (!have || score < best) begin
                    have = 1; best = score; winner = 2'(k);
                end
            end
            prev_one = SW_ONE[winner];
            prev_two = SW_TWO[winner];
            c.sw_one = prev_one; c.sw_two = prev_two; c.bias = bias;
            c.vo_ref = vo_ref_r; c.ib_ref = ib_ref[31:0]; c.is_ref = is_ref[31:0];
            pending.push_back(c);
        endfunction

        function void check_result(logic [103:0] d);
            t_choice e;
            if (pending.size() == 0) begin
                $error("result with no pending sample: %h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (d[0] !== e.sw_one) begin
                $error("switch_one exp %0d got %0d", e.sw_one, d[0]); errors++;
            end
            if (d[1] !== e.sw_two) begin
                $error("switch_two exp %0d got %0d", e.sw_two, d[1]); errors++;
            end
            if (d[2] !== e.bias) begin
                $error("bias_bit exp %0d got %0d", e.bias, d[2]); errors++;
            end
            if (d[33:3] !== e.vo_ref) begin
                $error("vo_reference exp %h got %h", e.vo_ref, d[33:3]); errors++;
            end
            if (d[65:34] !== e.ib_ref) begin
                $error("battery_current_reference exp %h got %h", e.ib_ref, d[65:34]);
                errors++;
            end
            if (d[97:66] !== e.is_ref) begin
                $error("source_current_reference exp %h got %h", e.is_ref, d[97:66]);
                errors++;
            end
            if (d[103:98] !== 6'd0) begin
                $error("pad bits exp 0 got %h", d[103:98]); errors++;
            end
        endfunction
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic [159:0] i_s_tdata = '0;
    logic [2:0]   i_s_tuser = '0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [103:0] o_m_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic         i_cfg_valid = 0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;

    switch_scoreboard sb = new();
    bit calm = 0;      // no idling on either side while set
    int sent = 0;

    fcs_mpc_converter_switch_select u_top (.*);

    always #5 i_clk = ~i_clk;

    // Result side: random stalls, check at each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
        i_m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    // Advance one edge first so valid never drops and rises in the same step
    task automatic cfg_write(t_reg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1; i_cfg_addr <= idx; i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.write_reg(idx, v);
    endtask

    // Wait for every pending choice, then let the sequencer settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // The block drops ready after each item, so the leading edge costs no rate
    task automatic send(logic [159:0] d, logic [2:0] mode);
        @(posedge i_clk);
        if (!calm) while ($urandom_range(99) < 8) @(posedge i_clk);
        i_s_tvalid <= 1; i_s_tdata <= d; i_s_tuser <= mode;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(d, mode);
        sent++;
        i_s_tvalid <= 0;
    endtask

    function automatic logic [31:0] rval();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(65536 * 500);
            4: return -$urandom_range(65536 * 500);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [159:0] rsample();
        return {rval(), rval(), rval(), rval(), rval()};
    endfunction

    // Mostly valid modes, occasionally a hold code
    function automatic logic [2:0] rmode();
        if ($urandom_range(9) == 0) return 3'($urandom_range(7));
        return 3'($urandom_range(1, 4));
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) send(rsample(), rmode());
    endtask

    initial begin
        logic [31:0] vin_ok;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: each mode, hold codes, zero divisors, field extremes
        vin_ok = 32'd400 << 16;
        send({32'd0, 32'd200 << 16, 32'd400 << 16, 32'd0, vin_ok}, MODE_ONE);
        send({32'd0, 32'd200 << 16, 32'd400 << 16, 32'd0, vin_ok}, MODE_TWO);
        send({32'd0, 32'd200 << 16, 32'd400 << 16, 32'd0, vin_ok}, MODE_THREE);
        send({32'd0, 32'd200 << 16, 32'd400 << 16, 32'd0, vin_ok}, MODE_FOUR);
        send({32'd1 << 16, 32'd0, 32'd0, 32'd0, 32'd0}, MODE_ONE);     // zero Vin
        send({32'd1 << 16, 32'd0, 32'd0, 32'd0, 32'd0}, MODE_FOUR);    // zero Vb
        send({32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 3'd0);               // hold
        send({32'd5, 32'd5, 32'd5, 32'd5, 32'd5}, 3'd5);
        send({32'd5, 32'd5, 32'd5, 32'd5, 32'd5}, 3'd6);
        send({32'd5, 32'd5, 32'd5, 32'd5, 32'd5}, 3'd7);
        send({5{32'h7FFF_FFFF}}, MODE_ONE);
        send({5{32'h8000_0000}}, MODE_THREE);
        send({5{32'hFFFF_FFFF}}, MODE_TWO);
        send({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1},
             MODE_FOUR);
        send({32'd0, 32'd0, 32'd0, 32'd0, 32'd1}, MODE_ONE);            // tiny divisor
        send({32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'hFFFF_FFFF}, MODE_THREE);

        // Pause until everything arrived, then default settings at random
        drain();
        random_phase(300);

        // Extreme settings: all ones
        drain();
        cfg_write(REG_TS_OVER_LB, 32'hFFFF_FFFF);
        cfg_write(REG_TS_OVER_LS, 32'hFFFF_FFFF);
        cfg_write(REG_TS_OVER_CO, 32'hFFFF_FFFF);
        cfg_write(REG_VO_DECAY,   32'hFFFF_FFFF);
        cfg_write(REG_REF_VO,     32'hFFFF_FFFF);
        cfg_write(REG_REF_IB_MAG, 32'hFFFF_FFFF);
        cfg_write(REG_REF_POWER,  32'hFFFF_FFFF);
        random_phase(250);

        // All zeros, idling off to cover back-to-back items
        drain();
        calm = 1;
        cfg_write(REG_TS_OVER_LB, 32'd0);
        cfg_write(REG_TS_OVER_LS, 32'd0);
        cfg_write(REG_TS_OVER_CO, 32'd0);
        cfg_write(REG_VO_DECAY,   32'd0);
        cfg_write(REG_REF_VO,     32'd0);
        cfg_write(REG_REF_IB_MAG, 32'd0);
        cfg_write(REG_REF_POWER,  32'd0);
        random_phase(250);
        calm = 0;

        // Random settings, several rounds
        for (int r = 0; r < 3; r++) begin
            drain();
            for (int k = 0; k < 7; k++) cfg_write(t_reg_idx'(k), $urandom);
            random_phase(200);
        end

        drain();
        $display("Covered %0d samples over default, extreme and random settings,", sent);
        $display("%0d choices checked, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("** fcs_mpc_converter_switch_select: PASSED **");
        end else begin
            $display("** fcs_mpc_converter_switch_select: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("** fcs_mpc_converter_switch_select: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
src/fmsc_pkg.sv
src/fmsc_mul.sv
src/fmsc_div.sv
src/fcs_mpc_converter_switch_select.sv
sim/tb_fcs_mpc_converter_switch_select.sv
